FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by mdansi_back; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CHK_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("property check failed");
// condition must never be seen outside reset
`define CHK_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define CHK_PROP(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: hw/rtl/mdansi_pkg.sv
// ---------------------------------------------------------------------------
// mdansi_pkg
// Types, character codes and SGR sequence tables for the markdown renderer.
// ---------------------------------------------------------------------------
`default_nettype none

package mdansi_pkg;

	// command codes on the input channel
	localparam logic [1:0] CMD_TEXT  = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// characters the renderer cares about
	localparam logic [7:0] CH_ESC  = 8'h1b;
	localparam logic [7:0] CH_LBR  = 8'h5b;
	localparam logic [7:0] CH_M    = 8'h6d;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_US   = 8'h5f;
	localparam logic [7:0] CH_BQ   = 8'h60;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BSL  = 8'h5c;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D1   = 8'h31;
	localparam logic [7:0] CH_D2   = 8'h32;
	localparam logic [7:0] CH_D3   = 8'h33;
	localparam logic [7:0] CH_D4   = 8'h34;

	// most tokens one input can cause (heading: three hashes, space, bold)
	localparam int MAX_TOK = 5;

	typedef enum logic [2:0] {
		SGR_RESET,
		SGR_BOLD_ON,
		SGR_BOLD_OFF,
		SGR_ITAL_ON,
		SGR_ITAL_OFF,
		SGR_UL_ON,
		SGR_UL_OFF
	} sgr_t;

	// one output token: a literal byte or a whole SGR sequence
	typedef struct packed {
		logic       is_sgr;
		sgr_t       code;
		logic [7:0] lit;
	} tok_t;

	// everything one input item emits
	typedef struct packed {
		tok_t [MAX_TOK-1:0] toks;
		logic [2:0]         ntok;
	} burst_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_byte;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_req_t;

	// length of an SGR sequence in bytes
	function automatic logic [2:0] sgr_len(sgr_t c);
		logic [2:0] n;
		case (c)
			SGR_BOLD_OFF, SGR_ITAL_OFF, SGR_UL_OFF: n = 3'd5;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

	// byte i of an SGR sequence: ESC [ digits m
	function automatic logic [7:0] sgr_char(sgr_t c, logic [2:0] i);
		logic [7:0] d0;
		logic [7:0] d1;
		logic       two;
		logic [7:0] r;
		two = 1'b0;
		d1  = CH_M;
		case (c)
			SGR_RESET:    d0 = CH_D0;
			SGR_BOLD_ON:  d0 = CH_D1;
			SGR_ITAL_ON:  d0 = CH_D3;
			SGR_UL_ON:    d0 = CH_D4;
			SGR_BOLD_OFF: begin d0 = CH_D2; d1 = CH_D2; two = 1'b1; end
			SGR_ITAL_OFF: begin d0 = CH_D2; d1 = CH_D3; two = 1'b1; end
			SGR_UL_OFF:   begin d0 = CH_D2; d1 = CH_D4; two = 1'b1; end
			default:      d0 = CH_D0;
		endcase
		case (i)
			3'd0:    r = CH_ESC;
			3'd1:    r = CH_LBR;
			3'd2:    r = d0;
			3'd3:    r = two ? d1 : CH_M;
			default: r = CH_M;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mdansi_front.sv
// ---------------------------------------------------------------------------
// mdansi_front
// Accepts commands, runs the markdown parse state and emits one token burst.
// ---------------------------------------------------------------------------
`default_nettype none

module mdansi_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  md_valid,
	input  wire mdansi_pkg::in_req_t   md_data,
	output logic                       md_stall,
	input  wire logic                  q_full,
	output logic                       push,
	output mdansi_pkg::burst_t         push_data
);

	typedef struct packed {
		mdansi_pkg::burst_t b;
		logic               pa;
	} work_t;

	function automatic logic is_word(logic [7:0] x);
		return (x >= 8'h30 && x <= 8'h39) || (x >= 8'h41 && x <= 8'h5a) ||
			(x >= 8'h61 && x <= 8'h7a);
	endfunction

	function automatic logic is_space(logic [7:0] x);
		return x == mdansi_pkg::CH_SP || x == mdansi_pkg::CH_TAB ||
			x == mdansi_pkg::CH_NL || x == mdansi_pkg::CH_CR;
	endfunction

	function automatic work_t f_byte(work_t w, logic [7:0] v);
		work_t r;
		r = w;
		if (r.b.ntok < 3'(mdansi_pkg::MAX_TOK)) begin
			r.b.toks[r.b.ntok] = '{is_sgr: 1'b0, code: mdansi_pkg::SGR_RESET, lit: v};
			r.b.ntok = r.b.ntok + 3'd1;
		end
		r.pa = is_word(v);
		return r;
	endfunction

	function automatic work_t f_sgr(work_t w, mdansi_pkg::sgr_t c);
		work_t r;
		r = w;
		if (r.b.ntok < 3'(mdansi_pkg::MAX_TOK)) begin
			r.b.toks[r.b.ntok] = '{is_sgr: 1'b1, code: c, lit: 8'h00};
			r.b.ntok = r.b.ntok + 3'd1;
		end
		// every sequence ends in 'm'
		r.pa = 1'b1;
		return r;
	endfunction

	function automatic work_t f_held(work_t w, logic [2:0][7:0] hb, logic [1:0] n);
		work_t r;
		r = w;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < n)
				r = f_byte(r, hb[i]);
		end
		return r;
	endfunction

	logic [2:0][7:0] held_q;
	logic [1:0]      held_cnt_q;
	logic            bold_q, ital_q, ul_q, head_q, fence_q, ls_q, alnum_q;

	logic [2:0][7:0] hb;
	logic [1:0]      cnt;
	logic            bold, ital, ul, head, fence, ls, done;
	logic [7:0]      c;
	logic [7:0]      h;
	work_t           w;
	logic            accept;

	assign md_stall = q_full;
	assign accept   = md_valid && !q_full;
	assign push     = accept && (w.b.ntok != 3'd0);
	assign push_data = w.b;
	assign c = md_data.in_byte;
	assign h = held_q[0];

	// classify the request and build its burst
	always_comb begin
		w     = '0;
		w.pa  = alnum_q;
		hb    = held_q;
		cnt   = held_cnt_q;
		bold  = bold_q;
		ital  = ital_q;
		ul    = ul_q;
		head  = head_q;
		fence = fence_q;
		ls    = ls_q;
		done  = 1'b0;
		case (md_data.cmd)
			mdansi_pkg::CMD_TEXT: begin
				// fence pass-through
				if (fence) begin
					if (ls && c == mdansi_pkg::CH_BQ) begin
						if (cnt < 2'd3) begin
							hb[cnt] = c;
							cnt = cnt + 2'd1;
						end
						if (cnt == 2'd3) begin
							w = f_held(w, hb, cnt);
							cnt = 2'd0;
							fence = 1'b0;
							ls = 1'b0;
						end
					end else begin
						w = f_held(w, hb, cnt);
						cnt = 2'd0;
						w = f_byte(w, c);
						ls = (c == mdansi_pkg::CH_NL);
					end
					done = 1'b1;
				end
				// resolve held delimiters
				if (!done && cnt != 2'd0) begin
					if (h == mdansi_pkg::CH_BSL) begin
						cnt = 2'd0;
						if (c == mdansi_pkg::CH_STAR || c == mdansi_pkg::CH_US ||
							c == mdansi_pkg::CH_BQ || c == mdansi_pkg::CH_HASH ||
							c == mdansi_pkg::CH_BSL) begin
							w = f_byte(w, c);
							ls = 1'b0;
						end else begin
							w = f_byte(w, mdansi_pkg::CH_BSL);
							w = f_byte(w, c);
							ls = (c == mdansi_pkg::CH_NL);
						end
						done = 1'b1;
					end else if (h == mdansi_pkg::CH_STAR && cnt == 2'd1) begin
						if (c == mdansi_pkg::CH_STAR) begin
							hb[cnt] = c;
							cnt = cnt + 2'd1;
							done = 1'b1;
						end else if (ls && c == mdansi_pkg::CH_SP) begin
							// bullet star stays literal
							w = f_held(w, hb, cnt);
							cnt = 2'd0;
							w = f_byte(w, c);
							ls = 1'b0;
							done = 1'b1;
						end else begin
							cnt = 2'd0;
							w = f_sgr(w, ital ? mdansi_pkg::SGR_ITAL_OFF :
								mdansi_pkg::SGR_ITAL_ON);
							ital = !ital;
						end
					end else if (h == mdansi_pkg::CH_STAR && cnt == 2'd2) begin
						cnt = 2'd0;
						w = f_sgr(w, bold ? mdansi_pkg::SGR_BOLD_OFF :
							mdansi_pkg::SGR_BOLD_ON);
						bold = !bold;
						if (c == mdansi_pkg::CH_STAR) begin
							w = f_sgr(w, ital ? mdansi_pkg::SGR_ITAL_OFF :
								mdansi_pkg::SGR_ITAL_ON);
							ital = !ital;
							done = 1'b1;
						end
					end else if (h == mdansi_pkg::CH_US) begin
						cnt = 2'd0;
						if (!ital && is_space(c)) begin
							w = f_byte(w, mdansi_pkg::CH_US);
							ls = 1'b0;
						end else begin
							w = f_sgr(w, ital ? mdansi_pkg::SGR_ITAL_OFF :
								mdansi_pkg::SGR_ITAL_ON);
							ital = !ital;
						end
					end else if (h == mdansi_pkg::CH_BQ) begin
						if (cnt == 2'd1) begin
							if (c == mdansi_pkg::CH_BQ) begin
								hb[cnt] = c;
								cnt = cnt + 2'd1;
								done = 1'b1;
							end else begin
								cnt = 2'd0;
								w = f_sgr(w, ul ? mdansi_pkg::SGR_UL_OFF :
									mdansi_pkg::SGR_UL_ON);
								ul = !ul;
							end
						end else if (cnt == 2'd2) begin
							cnt = 2'd0;
							w = f_byte(w, mdansi_pkg::CH_BQ);
							w = f_byte(w, mdansi_pkg::CH_BQ);
							if (c == mdansi_pkg::CH_BQ) begin
								w = f_byte(w, mdansi_pkg::CH_BQ);
								if (ls)
									fence = 1'b1;
								done = 1'b1;
							end
							ls = 1'b0;
						end
					end else if (h == mdansi_pkg::CH_HASH) begin
						if (c == mdansi_pkg::CH_HASH && cnt < 2'd3) begin
							hb[cnt] = c;
							cnt = cnt + 2'd1;
							done = 1'b1;
						end else if (c == mdansi_pkg::CH_SP) begin
							// heading opens
							w = f_held(w, hb, cnt);
							cnt = 2'd0;
							w = f_byte(w, mdansi_pkg::CH_SP);
							if (!bold) begin
								w = f_sgr(w, mdansi_pkg::SGR_BOLD_ON);
								bold = 1'b1;
							end
							head = 1'b1;
							ls = 1'b0;
							done = 1'b1;
						end else begin
							w = f_held(w, hb, cnt);
							cnt = 2'd0;
							ls = 1'b0;
						end
					end
				end
				// handle the byte itself
				if (!done) begin
					case (c)
						mdansi_pkg::CH_BSL, mdansi_pkg::CH_STAR, mdansi_pkg::CH_BQ: begin
							if (cnt < 2'd3) begin
								hb[cnt] = c;
								cnt = cnt + 2'd1;
							end
						end
						mdansi_pkg::CH_US: begin
							if (!ital && w.pa) begin
								w = f_byte(w, c);
								ls = 1'b0;
							end else if (cnt < 2'd3) begin
								hb[cnt] = c;
								cnt = cnt + 2'd1;
							end
						end
						mdansi_pkg::CH_HASH: begin
							if (ls) begin
								if (cnt < 2'd3) begin
									hb[cnt] = c;
									cnt = cnt + 2'd1;
								end
							end else begin
								w = f_byte(w, c);
								ls = 1'b0;
							end
						end
						mdansi_pkg::CH_NL: begin
							if (head) begin
								w = f_sgr(w, mdansi_pkg::SGR_BOLD_OFF);
								head = 1'b0;
								bold = 1'b0;
							end
							w = f_byte(w, c);
							ls = 1'b1;
						end
						default: begin
							w = f_byte(w, c);
							ls = 1'b0;
						end
					endcase
				end
			end
			mdansi_pkg::CMD_FLUSH: begin
				if (cnt != 2'd0) begin
					if (h == mdansi_pkg::CH_STAR && cnt == 2'd2) begin
						w = f_sgr(w, bold ? mdansi_pkg::SGR_BOLD_OFF :
							mdansi_pkg::SGR_BOLD_ON);
						bold = !bold;
					end else if (h == mdansi_pkg::CH_STAR && cnt == 2'd1 && ital) begin
						w = f_sgr(w, mdansi_pkg::SGR_ITAL_OFF);
						ital = 1'b0;
					end else if (h == mdansi_pkg::CH_US && ital) begin
						w = f_sgr(w, mdansi_pkg::SGR_ITAL_OFF);
						ital = 1'b0;
					end else if (h == mdansi_pkg::CH_BQ && cnt == 2'd1 && ul) begin
						w = f_sgr(w, mdansi_pkg::SGR_UL_OFF);
						ul = 1'b0;
					end else begin
						w = f_held(w, hb, cnt);
					end
					cnt = 2'd0;
				end
				if (bold || ital || ul || head)
					w = f_sgr(w, mdansi_pkg::SGR_RESET);
				bold  = 1'b0;
				ital  = 1'b0;
				ul    = 1'b0;
				head  = 1'b0;
				fence = 1'b0;
				ls    = 1'b1;
			end
			mdansi_pkg::CMD_RESET: begin
				cnt = 2'd0;
				if (bold || ital || ul || head)
					w = f_sgr(w, mdansi_pkg::SGR_RESET);
				bold  = 1'b0;
				ital  = 1'b0;
				ul    = 1'b0;
				head  = 1'b0;
				fence = 1'b0;
				ls    = 1'b1;
			end
			default: begin
				// unused command: no effect
			end
		endcase
	end

	// advance parse state on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			bold_q     <= 1'b0;
			ital_q     <= 1'b0;
			ul_q       <= 1'b0;
			head_q     <= 1'b0;
			fence_q    <= 1'b0;
			ls_q       <= 1'b1;
			alnum_q    <= 1'b0;
		end else if (accept) begin
			held_cnt_q <= cnt;
			bold_q     <= bold;
			ital_q     <= ital;
			ul_q       <= ul;
			head_q     <= head;
			fence_q    <= fence;
			ls_q       <= ls;
			alnum_q    <= w.pa;
		end
	end

	// held delimiter bytes, read only below the count
	always_ff @(posedge clk) begin
		if (accept)
			held_q <= hb;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mdansi_queue.sv
// ---------------------------------------------------------------------------
// mdansi_queue
// Short FIFO of token bursts between the parser and the byte serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module mdansi_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mdansi_pkg::burst_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output mdansi_pkg::burst_t      head
);

	// DEPTH of two or more
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mdansi_pkg::burst_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// store a burst
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mdansi_back.sv
// ---------------------------------------------------------------------------
// mdansi_back
// Expands bursts into bytes in an output reg, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mdansi_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire mdansi_pkg::burst_t   head,
	output logic                      pop,
	output logic                      ansi_valid,
	input  wire logic                 ansi_stall,
	output mdansi_pkg::out_req_t      ansi_data
);

	logic [2:0]           tix_q, cix_q;
	logic                 out_valid_q;
	mdansi_pkg::out_req_t out_q;

	mdansi_pkg::tok_t tok;
	logic [7:0]       cur_byte;
	logic             tok_end, burst_end, load;

	assign tok       = head.toks[tix_q];
	assign cur_byte  = tok.is_sgr ? mdansi_pkg::sgr_char(tok.code, cix_q) : tok.lit;
	assign tok_end   = !tok.is_sgr || (cix_q == mdansi_pkg::sgr_len(tok.code) - 3'd1);
	assign burst_end = tok_end && (tix_q == head.ntok - 3'd1);
	assign load      = head_valid && (!out_valid_q || !ansi_stall);
	assign pop       = load && burst_end;

	assign ansi_valid = out_valid_q;
	assign ansi_data  = out_q;

	// walk tokens and sequence bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tix_q       <= 3'd0;
			cix_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (tok_end) begin
				cix_q <= 3'd0;
				tix_q <= burst_end ? 3'd0 : tix_q + 3'd1;
			end else begin
				cix_q <= cix_q + 3'd1;
			end
		end else if (!ansi_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load)
			out_q <= '{out_byte: cur_byte, last: burst_end};
	end

	`CHK_PROP(a_tix_in_burst, clk, arst_n, head_valid |-> (tix_q < head.ntok))
	`CHK_PROP(a_cix_in_seq, clk, arst_n, (head_valid && tok.is_sgr) |-> (cix_q < mdansi_pkg::sgr_len(tok.code)))
	`CHK_NEVER(a_no_empty_burst, clk, arst_n, head_valid && (head.ntok == 3'd0))
	`CHK_PROP(a_pop_rewinds, clk, arst_n, pop |=> ((tix_q == 3'd0) && (cix_q == 3'd0)))

endmodule

`default_nettype wire

FILE: hw/rtl/markdown_to_ansi_stream.sv
// ---------------------------------------------------------------------------
// markdown_to_ansi_stream
// Streaming markdown renderer that inserts ANSI SGR sequences into text.
// ---------------------------------------------------------------------------
// Input channel md: one request per command (text byte, end-of-stream flush,
// style/state reset). Output channel ansi: rendered bytes; last marks the
// final byte caused by one request, and a request that only holds delimiter
// bytes causes none.
// A request's bytes pass through the burst queue, then the output register.
// Throughput, while ansi_stall is low: one output byte per cycle, set by the
// serializer; plain text runs at one request per cycle. A request of N bytes
// (up to eleven, escape sequences included) holds the serializer until the
// last is loaded, and md_stall rises once the burst queue is full.
// Reset (arst_n low) clears styles, held delimiters and the queue; line
// start is set. When the receiver stalls, the output register holds its byte
// and the queue fills; the input then stalls while previous results wait.
// ---------------------------------------------------------------------------
`default_nettype none

module markdown_to_ansi_stream #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 md_valid,
	output logic                      md_stall,
	input  wire mdansi_pkg::in_req_t  md_data,
	output logic                      ansi_valid,
	input  wire logic                 ansi_stall,
	output mdansi_pkg::out_req_t      ansi_data
);

	logic               push, q_full, pop, head_valid;
	mdansi_pkg::burst_t push_data, head;

	mdansi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.md_valid  (md_valid),
		.md_data   (md_data),
		.md_stall  (md_stall),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	mdansi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mdansi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ansi_valid (ansi_valid),
		.ansi_stall (ansi_stall),
		.ansi_data  (ansi_data)
	);

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Streams markdown text, flush, reset and unused commands into the renderer.
// An in-bench renderer model predicts every output byte. The scoreboard
// matches each output against the oldest predicted byte under four mixes
// of sender idling and receiver stalling.
// ---------------------------------------------------------------------------

module testbench;

	// command code the block leaves unused
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// SGR parameter digits, one or two characters
	localparam logic [15:0] SEQ_RESET    = "0";
	localparam logic [15:0] SEQ_BOLD_ON  = "1";
	localparam logic [15:0] SEQ_BOLD_OFF = "22";
	localparam logic [15:0] SEQ_ITAL_ON  = "3";
	localparam logic [15:0] SEQ_ITAL_OFF = "23";
	localparam logic [15:0] SEQ_UL_ON    = "4";
	localparam logic [15:0] SEQ_UL_OFF   = "24";

	localparam int MAX_BURST    = 11;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE_CYCLE = 30;

	// renderer model and expected byte store
	class md_scoreboard;
		logic [7:0]           held[3];
		int unsigned          held_n;
		bit                   bold, ital, ul, head, fence, at_start, after_word;
		logic [7:0]           burst[$];
		mdansi_pkg::out_req_t expected[$];
		int unsigned          errors;
		int unsigned          matched;

		function new();
			held_n   = 0;
			at_start = 1'b1;
			errors   = 0;
			matched  = 0;
		endfunction

		function bit is_word(logic [7:0] x);
			return (x >= "0" && x <= "9") || (x >= "A" && x <= "Z") ||
				(x >= "a" && x <= "z");
		endfunction

		function bit is_space(logic [7:0] x);
			return x == mdansi_pkg::CH_SP || x == mdansi_pkg::CH_TAB ||
				x == mdansi_pkg::CH_NL || x == mdansi_pkg::CH_CR;
		endfunction

		// emitted bytes, escape bytes included, drive the word tracking
		function void emit(logic [7:0] b);
			if (burst.size() < MAX_BURST)
				burst.push_back(b);
			after_word = is_word(b);
		endfunction

		function void emit_sgr(logic [15:0] digits);
			emit(mdansi_pkg::CH_ESC);
			emit(mdansi_pkg::CH_LBR);
			if (digits[15:8] != 8'h00)
				emit(digits[15:8]);
			emit(digits[7:0]);
			emit(mdansi_pkg::CH_M);
		endfunction

		function void emit_held();
			for (int i = 0; i < held_n && i < 3; i++)
				emit(held[i]);
			held_n = 0;
		endfunction

		function void hold_byte(logic [7:0] b);
			if (held_n < 3) begin
				held[held_n] = b;
				held_n++;
			end
		endfunction

		function void swap_bold();
			emit_sgr(bold ? SEQ_BOLD_OFF : SEQ_BOLD_ON);
			bold = !bold;
		endfunction

		function void swap_italic();
			emit_sgr(ital ? SEQ_ITAL_OFF : SEQ_ITAL_ON);
			ital = !ital;
		endfunction

		function void swap_underline();
			emit_sgr(ul ? SEQ_UL_OFF : SEQ_UL_ON);
			ul = !ul;
		endfunction

		function void render_byte(logic [7:0] c);
			logic [7:0] h;
			// pass fenced text through, watch for the closing backticks
			if (fence) begin
				if (at_start && c == mdansi_pkg::CH_BQ) begin
					hold_byte(c);
					if (held_n == 3) begin
						emit_held();
						fence    = 1'b0;
						at_start = 1'b0;
					end
					return;
				end
				emit_held();
				emit(c);
				at_start = (c == mdansi_pkg::CH_NL);
				return;
			end

			// resolve held delimiters against the new byte
			if (held_n > 0) begin
				h = held[0];
				if (h == mdansi_pkg::CH_BSL) begin
					held_n = 0;
					if (c == mdansi_pkg::CH_STAR || c == mdansi_pkg::CH_US ||
						c == mdansi_pkg::CH_BQ || c == mdansi_pkg::CH_HASH ||
						c == mdansi_pkg::CH_BSL) begin
						emit(c);
						at_start = 1'b0;
					end else begin
						emit(mdansi_pkg::CH_BSL);
						emit(c);
						at_start = (c == mdansi_pkg::CH_NL);
					end
					return;
				end
				if (h == mdansi_pkg::CH_STAR && held_n == 1) begin
					if (c == mdansi_pkg::CH_STAR) begin
						hold_byte(c);
						return;
					end
					// bullet: star and space at line start stay literal
					if (at_start && c == mdansi_pkg::CH_SP) begin
						emit_held();
						emit(c);
						at_start = 1'b0;
						return;
					end
					held_n = 0;
					swap_italic();
				end else if (h == mdansi_pkg::CH_STAR && held_n == 2) begin
					held_n = 0;
					swap_bold();
					if (c == mdansi_pkg::CH_STAR) begin
						swap_italic();
						return;
					end
				end else if (h == mdansi_pkg::CH_US) begin
					held_n = 0;
					if (!ital && is_space(c)) begin
						emit(mdansi_pkg::CH_US);
						at_start = 1'b0;
					end else begin
						swap_italic();
					end
				end else if (h == mdansi_pkg::CH_BQ) begin
					if (held_n == 1) begin
						if (c == mdansi_pkg::CH_BQ) begin
							hold_byte(c);
							return;
						end
						held_n = 0;
						swap_underline();
					end else if (held_n == 2) begin
						held_n = 0;
						if (c == mdansi_pkg::CH_BQ) begin
							emit(mdansi_pkg::CH_BQ);
							emit(mdansi_pkg::CH_BQ);
							emit(mdansi_pkg::CH_BQ);
							if (at_start)
								fence = 1'b1;
							at_start = 1'b0;
							return;
						end
						emit(mdansi_pkg::CH_BQ);
						emit(mdansi_pkg::CH_BQ);
						at_start = 1'b0;
					end
				end else if (h == mdansi_pkg::CH_HASH) begin
					if (c == mdansi_pkg::CH_HASH && held_n < 3) begin
						hold_byte(c);
						return;
					end
					// heading: hashes and a space open bold to the newline
					if (c == mdansi_pkg::CH_SP) begin
						emit_held();
						emit(mdansi_pkg::CH_SP);
						if (!bold) begin
							emit_sgr(SEQ_BOLD_ON);
							bold = 1'b1;
						end
						head     = 1'b1;
						at_start = 1'b0;
						return;
					end
					emit_held();
					at_start = 1'b0;
				end
			end

			// handle the new byte itself
			case (c)
				mdansi_pkg::CH_BSL,
				mdansi_pkg::CH_STAR,
				mdansi_pkg::CH_BQ: hold_byte(c);
				mdansi_pkg::CH_US: begin
					// underscore inside a word stays literal
					if (!ital && after_word) begin
						emit(c);
						at_start = 1'b0;
					end else begin
						hold_byte(c);
					end
				end
				mdansi_pkg::CH_HASH: begin
					if (at_start) begin
						hold_byte(c);
					end else begin
						emit(c);
						at_start = 1'b0;
					end
				end
				mdansi_pkg::CH_NL: begin
					if (head) begin
						emit_sgr(SEQ_BOLD_OFF);
						head = 1'b0;
						bold = 1'b0;
					end
					emit(c);
					at_start = 1'b1;
				end
				default: begin
					emit(c);
					at_start = 1'b0;
				end
			endcase
		endfunction

		function void close_styles();
			if (bold || ital || ul || head)
				emit_sgr(SEQ_RESET);
			bold     = 1'b0;
			ital     = 1'b0;
			ul       = 1'b0;
			head     = 1'b0;
			fence    = 1'b0;
			at_start = 1'b1;
		endfunction

		function void flush_stream();
			logic [7:0] h;
			if (held_n > 0) begin
				h = held[0];
				if (h == mdansi_pkg::CH_STAR && held_n == 2)
					swap_bold();
				else if (h == mdansi_pkg::CH_STAR && held_n == 1 && ital)
					swap_italic();
				else if (h == mdansi_pkg::CH_US && ital)
					swap_italic();
				else if (h == mdansi_pkg::CH_BQ && held_n == 1 && ul)
					swap_underline();
				else
					emit_held();
				held_n = 0;
			end
			close_styles();
		endfunction

		// predict the output bytes of one accepted request
		function void note_request(mdansi_pkg::in_req_t r);
			mdansi_pkg::out_req_t e;
			burst.delete();
			case (r.cmd)
				mdansi_pkg::CMD_TEXT:  render_byte(r.in_byte);
				mdansi_pkg::CMD_FLUSH: flush_stream();
				mdansi_pkg::CMD_RESET: begin
					held_n = 0;
					close_styles();
				end
				default: ;
			endcase
			foreach (burst[i]) begin
				e.out_byte = burst[i];
				e.last     = (i + 1 == burst.size());
				expected.push_back(e);
			end
		endfunction

		function void check_result(mdansi_pkg::out_req_t got);
			mdansi_pkg::out_req_t want;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t unexpected output: byte %h last %b", $time,
						got.out_byte, got.last);
				return;
			end
			want = expected.pop_front();
			if (got.out_byte !== want.out_byte || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("%t mismatch: byte %h last %b, expected byte %h last %b",
						$time, got.out_byte, got.last, want.out_byte, want.last);
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 md_valid   = 1'b0;
	logic                 md_stall;
	mdansi_pkg::in_req_t  md_data    = '0;
	logic                 ansi_valid;
	logic                 ansi_stall = 1'b0;
	mdansi_pkg::out_req_t ansi_data;

	md_scoreboard sb = new();
	int unsigned  idle_pct  = 0;
	int unsigned  stall_pct = 0;
	int unsigned  sent      = 0;

	markdown_to_ansi_stream i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.md_valid   (md_valid),
		.md_stall   (md_stall),
		.md_data    (md_data),
		.ansi_valid (ansi_valid),
		.ansi_stall (ansi_stall),
		.ansi_data  (ansi_data)
	);

	always #2 clk = ~clk;

	// stall the output at random
	always @(negedge clk) begin
		ansi_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// check every accepted output byte
	always @(posedge clk) begin
		if (arst_n && ansi_valid && !ansi_stall)
			sb.check_result(ansi_data);
	end

	// drive one request; enter and leave at a falling edge
	task automatic send_request(input mdansi_pkg::in_req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			md_valid <= 1'b0;
			@(negedge clk);
		end
		md_valid <= 1'b1;
		md_data  <= r;
		@(posedge clk);
		while (md_stall)
			@(posedge clk);
		sb.note_request(r);
		if (r.cmd != CMD_UNUSED)
			sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] b);
		mdansi_pkg::in_req_t r;
		r.cmd     = mdansi_pkg::CMD_TEXT;
		r.in_byte = b;
		send_request(r);
	endtask

	task automatic send_cmd(input logic [1:0] c);
		mdansi_pkg::in_req_t r;
		r.cmd     = c;
		r.in_byte = 8'($urandom_range(0, 255));
		send_request(r);
	endtask

	task automatic send_word();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0:       send_text(8'("a" + $urandom_range(0, 25)));
				1:       send_text(8'("A" + $urandom_range(0, 25)));
				default: send_text(8'("0" + $urandom_range(0, 9)));
			endcase
		end
	endtask

	task automatic send_delims(input logic [7:0] d, input int n);
		repeat (n) send_text(d);
	endtask

	// one random snippet: mostly well-formed markdown, some noise
	task automatic send_snippet();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_word();
			send_text(mdansi_pkg::CH_SP);
		end else if (pick < 30) begin
			send_delims(mdansi_pkg::CH_STAR, 2);
			send_word();
			send_delims(mdansi_pkg::CH_STAR, 2);
		end else if (pick < 38) begin
			send_text(mdansi_pkg::CH_STAR);
			send_word();
			send_text(mdansi_pkg::CH_STAR);
		end else if (pick < 43) begin
			send_delims(mdansi_pkg::CH_STAR, 3);
			send_word();
			send_delims(mdansi_pkg::CH_STAR, 3);
		end else if (pick < 50) begin
			send_text(mdansi_pkg::CH_SP);
			send_text(mdansi_pkg::CH_US);
			send_word();
			send_text(mdansi_pkg::CH_US);
		end else if (pick < 57) begin
			send_text(mdansi_pkg::CH_BQ);
			send_word();
			send_text(mdansi_pkg::CH_BQ);
		end else if (pick < 64) begin
			send_text(mdansi_pkg::CH_NL);
			send_delims(mdansi_pkg::CH_HASH, $urandom_range(1, 3));
			send_text(mdansi_pkg::CH_SP);
			send_word();
			send_text(mdansi_pkg::CH_NL);
		end else if (pick < 70) begin
			// fenced block with delimiters inside
			send_text(mdansi_pkg::CH_NL);
			send_delims(mdansi_pkg::CH_BQ, 3);
			send_text(mdansi_pkg::CH_NL);
			n = $urandom_range(1, 6);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0:       send_word();
					1:       send_text(mdansi_pkg::CH_BQ);
					2:       send_text(mdansi_pkg::CH_NL);
					default: send_text(8'($urandom_range(0, 255)));
				endcase
			end
			send_text(mdansi_pkg::CH_NL);
			send_delims(mdansi_pkg::CH_BQ, 3);
			send_text(mdansi_pkg::CH_NL);
		end else if (pick < 76) begin
			send_text(mdansi_pkg::CH_BSL);
			case ($urandom_range(0, 5))
				0:       send_text(mdansi_pkg::CH_STAR);
				1:       send_text(mdansi_pkg::CH_US);
				2:       send_text(mdansi_pkg::CH_BQ);
				3:       send_text(mdansi_pkg::CH_HASH);
				4:       send_text(mdansi_pkg::CH_BSL);
				default: send_text(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 80) begin
			send_text(mdansi_pkg::CH_NL);
			send_text(mdansi_pkg::CH_STAR);
			send_text(mdansi_pkg::CH_SP);
			send_word();
		end else if (pick < 84) begin
			send_text(mdansi_pkg::CH_NL);
		end else if (pick < 88) begin
			send_text(8'($urandom_range(0, 255)));
		end else if (pick < 91) begin
			send_text($urandom_range(0, 1) ? mdansi_pkg::CH_TAB : mdansi_pkg::CH_CR);
		end else if (pick < 95) begin
			case ($urandom_range(0, 3))
				0:       send_text(mdansi_pkg::CH_STAR);
				1:       send_text(mdansi_pkg::CH_US);
				2:       send_text(mdansi_pkg::CH_BQ);
				default: send_text(mdansi_pkg::CH_HASH);
			endcase
		end else if (pick < 97) begin
			send_cmd(mdansi_pkg::CMD_FLUSH);
		end else if (pick < 99) begin
			send_cmd(mdansi_pkg::CMD_RESET);
		end else begin
			send_cmd(CMD_UNUSED);
		end
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall);
		int unsigned stop_at;
		idle_pct  = idle;
		stall_pct = stall;
		stop_at   = sent + PHASE_ITEMS;
		while (sent < stop_at)
			send_snippet();
	endtask

	initial begin
		int drain;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// heading kept open across an escaped newline, then closed
		send_text(mdansi_pkg::CH_HASH);
		send_text(mdansi_pkg::CH_SP);
		send_text("a");
		send_text(mdansi_pkg::CH_BSL);
		send_text(mdansi_pkg::CH_NL);
		send_text(mdansi_pkg::CH_NL);
		// bullet
		send_text(mdansi_pkg::CH_STAR);
		send_text(mdansi_pkg::CH_SP);
		// stray underscores: after a word byte and before a space
		send_text("a");
		send_text(mdansi_pkg::CH_US);
		send_text(mdansi_pkg::CH_SP);
		send_text(mdansi_pkg::CH_US);
		send_text(mdansi_pkg::CH_SP);
		// bold and italic together, closed by a flush
		send_delims(mdansi_pkg::CH_STAR, 3);
		send_cmd(mdansi_pkg::CMD_FLUSH);
		// held double star resolved by a flush
		send_delims(mdansi_pkg::CH_STAR, 2);
		send_cmd(mdansi_pkg::CMD_FLUSH);
		// underline with byte extremes, then a reset with it open
		send_text(mdansi_pkg::CH_BQ);
		send_text(8'hff);
		send_text(8'h00);
		send_cmd(mdansi_pkg::CMD_RESET);
		send_cmd(CMD_UNUSED);

		run_phase(0, 0);
		run_phase(83, 0);
		run_phase(0, 83);
		run_phase(32, 32);

		// drain the output, then watch for stray bytes
		md_valid <= 1'b0;
		drain = 0;
		while (sb.expected.size() != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLE) @(negedge clk);
		if (sb.expected.size() != 0) begin
			$display("%0d expected output bytes never arrived", sb.expected.size());
			sb.errors++;
		end

		$display("summary: %0d requests of text, flush and reset under four idle mixes",
			sent);
		$display("summary: %0d output bytes matched, %0d mismatches", sb.matched,
			sb.errors);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// hard stop
	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mdansi_pkg.sv
hw/rtl/mdansi_front.sv
hw/rtl/mdansi_queue.sv
hw/rtl/mdansi_back.sv
hw/rtl/markdown_to_ansi_stream.sv
tb/sv/testbench.sv
